@@ src/elt_pkg.sv @@
// Package for the expression line tokenizer: mode and token codes, result
// records, character constants and the keyword and operator lookups.
// No dependencies.
package elt_pkg;

  typedef enum logic [4:0] {
    MODE_IDLE    = 5'b00001,
    MODE_NUM     = 5'b00010,
    MODE_WORD    = 5'b00100,
    MODE_COLON   = 5'b01000,
    MODE_DISCARD = 5'b10000
  } mode_t;

  localparam logic [4:0] K_LPAREN    = 5'd0;
  localparam logic [4:0] K_RPAREN    = 5'd1;
  localparam logic [4:0] K_POWER     = 5'd2;
  localparam logic [4:0] K_PLUS      = 5'd3;
  localparam logic [4:0] K_MINUS     = 5'd4;
  localparam logic [4:0] K_MULT      = 5'd5;
  localparam logic [4:0] K_DIV       = 5'd6;
  localparam logic [4:0] K_COMMA     = 5'd7;
  localparam logic [4:0] K_SUCH_THAT = 5'd8;
  localparam logic [4:0] K_NEWLINE   = 5'd9;
  localparam logic [4:0] K_NUMBER    = 5'd10;
  localparam logic [4:0] K_SIN       = 5'd11;
  localparam logic [4:0] K_COS       = 5'd12;
  localparam logic [4:0] K_TAN       = 5'd13;
  localparam logic [4:0] K_ARCSIN    = 5'd14;
  localparam logic [4:0] K_ARCCOS    = 5'd15;
  localparam logic [4:0] K_ARCTAN    = 5'd16;
  localparam logic [4:0] K_LOG       = 5'd17;
  localparam logic [4:0] K_VAR       = 5'd18;
  localparam logic [4:0] K_FILE      = 5'd19;
  localparam logic [4:0] K_BAD_COLON = 5'd20;
  localparam logic [4:0] K_UNKNOWN   = 5'd21;
  localparam logic [4:0] K_TOO_LONG  = 5'd22;

  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_POINT  = 8'h2E;
  localparam logic [7:0] CH_USCORE = 8'h5F;

  // keywords stored first character in the lowest byte
  localparam logic [23:0] KW_SIN    = {"n", "i", "s"};
  localparam logic [23:0] KW_COS    = {"s", "o", "c"};
  localparam logic [23:0] KW_TAN    = {"n", "a", "t"};
  localparam logic [23:0] KW_LOG    = {"g", "o", "l"};
  localparam logic [47:0] KW_ARCSIN = {"n", "i", "s", "c", "r", "a"};
  localparam logic [47:0] KW_ARCCOS = {"s", "o", "c", "c", "r", "a"};
  localparam logic [47:0] KW_ARCTAN = {"n", "a", "t", "c", "r", "a"};

  localparam int unsigned PREFIX_BYTES = 6;
  localparam int unsigned RQ_DEPTH     = 4;
  localparam int unsigned RQ_AW        = 2;

  typedef struct packed {
    logic [4:0] kind;
    logic [7:0] start;
    logic [8:0] length;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } push_t;

  function automatic logic [4:0] word_kind(input logic [47:0] pre, input logic [2:0] len,
                                           input logic pt);
    logic [4:0] k;
    k = pt ? K_FILE : K_VAR;
    if (len == 3'd3) begin
      if (pre[23:0] == KW_SIN) k = K_SIN;
      else if (pre[23:0] == KW_COS) k = K_COS;
      else if (pre[23:0] == KW_TAN) k = K_TAN;
      else if (pre[23:0] == KW_LOG) k = K_LOG;
    end else if (len == 3'd6) begin
      if (pre == KW_ARCSIN) k = K_ARCSIN;
      else if (pre == KW_ARCCOS) k = K_ARCCOS;
      else if (pre == KW_ARCTAN) k = K_ARCTAN;
    end
    return k;
  endfunction

  function automatic logic [4:0] op_kind(input logic [7:0] c);
    logic [4:0] k;
    case (c)
      8'h28:   k = K_LPAREN;
      8'h29:   k = K_RPAREN;
      8'h5E:   k = K_POWER;
      8'h2B:   k = K_PLUS;
      8'h2D:   k = K_MINUS;
      8'h2A:   k = K_MULT;
      8'h2F:   k = K_DIV;
      8'h2C:   k = K_COMMA;
      default: k = K_UNKNOWN;
    endcase
    return k;
  endfunction

endpackage

@@ src/elt_scan.sv @@
// Scanner of the expression line tokenizer: line state and per-byte token
// decisions, giving up to two results per accepted byte.
// Depends on elt_pkg.
module elt_scan
  import elt_pkg::*;
#(
  parameter int unsigned LINE_MAX = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       acc_i,
  input  logic [7:0] char_i,
  output push_t      push_o
);

  localparam int unsigned PW = $clog2(LINE_MAX + 1);

  mode_t       mode_r, mode_nxt;
  logic        pt_r, pt_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [7:0]  beg_r, beg_nxt;
  logic [8:0]  cnt_r, cnt_nxt;
  logic [2:0]  sat_r, sat_nxt;
  logic [47:0] pre_r, pre_nxt;

  logic        is_letter, is_digit, is_dot, is_eol;
  logic        pend_v, close;
  result_t     pend, main_res;
  logic        main_v;
  logic        ext_num, ext_word;

  assign is_letter = (char_i >= 8'h61 && char_i <= 8'h7A) || (char_i >= 8'h41 && char_i <= 8'h5A);
  assign is_digit  = char_i >= 8'h30 && char_i <= 8'h39;
  assign is_dot    = char_i == CH_POINT;
  assign is_eol    = char_i == CH_LF || char_i == CH_CR;
  assign ext_num   = (mode_r == MODE_NUM) && (is_digit || (is_dot && !pt_r));
  assign ext_word  = (mode_r == MODE_WORD) &&
                     (is_letter || char_i == CH_USCORE || (is_dot && !pt_r));

  always_comb begin
    pend_v = 1'b1;
    pend   = '0;
    case (mode_r)
      MODE_NUM: begin
        pend.kind   = K_NUMBER;
        pend.start  = beg_r;
        pend.length = cnt_r;
      end
      MODE_WORD: begin
        pend.kind   = word_kind(pre_r, sat_r, pt_r);
        pend.start  = beg_r;
        pend.length = cnt_r;
      end
      MODE_COLON: begin
        pend.kind   = K_BAD_COLON;
        pend.start  = beg_r;
        pend.length = 9'd1;
      end
      default: pend_v = 1'b0;
    endcase
  end

  always_comb begin
    mode_nxt = mode_r;
    pt_nxt   = pt_r;
    pos_nxt  = pos_r;
    beg_nxt  = beg_r;
    cnt_nxt  = cnt_r;
    sat_nxt  = sat_r;
    pre_nxt  = pre_r;
    close    = 1'b0;
    main_v   = 1'b0;
    main_res = '0;
    if (acc_i) begin
      if (is_eol) begin
        close           = mode_r != MODE_DISCARD;
        main_v          = 1'b1;
        main_res.kind   = K_NEWLINE;
        main_res.start  = 8'(pos_r);
        main_res.length = 9'd1;
        mode_nxt = MODE_IDLE;
        pt_nxt   = 1'b0;
        pos_nxt  = '0;
        beg_nxt  = '0;
        cnt_nxt  = '0;
        sat_nxt  = '0;
        pre_nxt  = '0;
      end else if (mode_r == MODE_DISCARD) begin
        mode_nxt = MODE_DISCARD;
      end else if (pos_r == PW'(LINE_MAX)) begin
        close         = 1'b1;
        main_v        = 1'b1;
        main_res.kind = K_TOO_LONG;
        mode_nxt      = MODE_DISCARD;
        pt_nxt        = 1'b0;
      end else begin
        pos_nxt = pos_r + PW'(1);
        if (mode_r == MODE_COLON) begin
          main_v         = 1'b1;
          main_res.start = beg_r;
          if (char_i == CH_COLON) begin
            main_res.kind   = K_SUCH_THAT;
            main_res.length = 9'd2;
            mode_nxt        = MODE_IDLE;
          end else begin
            main_res.kind   = K_BAD_COLON;
            main_res.length = 9'd1;
            mode_nxt        = MODE_DISCARD;
          end
        end else if (ext_num || ext_word) begin
          if (is_dot) pt_nxt = 1'b1;
          if (sat_r < 3'(PREFIX_BYTES)) pre_nxt[{sat_r, 3'b000} +: 8] = char_i;
          cnt_nxt = cnt_r + 9'd1;
          sat_nxt = sat_r + 3'(sat_r != 3'd7);
        end else begin
          close    = (mode_r == MODE_NUM) || (mode_r == MODE_WORD);
          mode_nxt = MODE_IDLE;
          pt_nxt   = 1'b0;
          if (char_i == CH_SPACE || char_i == CH_TAB) begin
            mode_nxt = MODE_IDLE;
          end else if (is_letter || is_digit) begin
            mode_nxt = is_letter ? MODE_WORD : MODE_NUM;
            beg_nxt  = 8'(pos_r);
            pre_nxt  = {40'b0, char_i};
            cnt_nxt  = 9'd1;
            sat_nxt  = 3'd1;
          end else if (char_i == CH_COLON) begin
            mode_nxt = MODE_COLON;
            beg_nxt  = 8'(pos_r);
          end else begin
            main_v          = 1'b1;
            main_res.kind   = op_kind(char_i);
            main_res.start  = 8'(pos_r);
            main_res.length = 9'd1;
            if (main_res.kind == K_UNKNOWN) mode_nxt = MODE_DISCARD;
          end
        end
      end
    end
  end

  always_comb begin
    push_o = '0;
    if (close && pend_v) begin
      push_o.r0 = pend;
      push_o.r1 = main_res;
      push_o.cnt = main_v ? 2'd2 : 2'd1;
      push_o.r1.last = 1'b1;
      push_o.r0.last = !main_v;
    end else if (main_v) begin
      push_o.r0 = main_res;
      push_o.r0.last = 1'b1;
      push_o.cnt = 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      pt_r   <= 1'b0;
      pos_r  <= '0;
      beg_r  <= '0;
      cnt_r  <= '0;
      sat_r  <= '0;
    end else begin
      mode_r <= mode_nxt;
      pt_r   <= pt_nxt;
      pos_r  <= pos_nxt;
      beg_r  <= beg_nxt;
      cnt_r  <= cnt_nxt;
      sat_r  <= sat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pre_r <= pre_nxt;
  end

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= PW'(LINE_MAX))
    else $error("line position beyond limit");

  a_discard_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_i && mode_r == MODE_DISCARD && !is_eol) |-> push_o.cnt == 2'd0)
    else $error("result while discarding");

  a_two_needs_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (push_o.cnt == 2'd2) |->
      (mode_r == MODE_NUM || mode_r == MODE_WORD || mode_r == MODE_COLON))
    else $error("two results without a pending token");

endmodule

@@ src/elt_rqueue.sv @@
// Result queue of the expression line tokenizer: takes up to two results per
// cycle, hands out one per transfer. Depends on elt_pkg.
module elt_rqueue
  import elt_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  push_t   push_i,
  output logic    space_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_res_o
);

  result_t          mem_r [RQ_DEPTH];
  logic [RQ_AW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [RQ_AW:0]   cnt_r, cnt_nxt;
  logic             pop;

  assign out_valid_o = cnt_r != '0;
  assign pop         = out_valid_o && out_ready_i;
  assign space_o     = cnt_r <= (RQ_AW + 1)'(RQ_DEPTH - 2);
  assign out_res_o   = mem_r[rd_r];
  assign wr_nxt      = wr_r + RQ_AW'(push_i.cnt);
  assign rd_nxt      = rd_r + RQ_AW'(pop);
  assign cnt_nxt     = cnt_r + (RQ_AW + 1)'(push_i.cnt) - (RQ_AW + 1)'(pop);

  always_ff @(posedge clk) begin
    if (push_i.cnt != 2'd0) mem_r[wr_r] <= push_i.r0;
    if (push_i.cnt == 2'd2) mem_r[wr_r + RQ_AW'(1)] <= push_i.r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push_i.cnt != 2'd0) |-> space_o)
    else $error("push into a full result queue");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (RQ_AW + 1)'(RQ_DEPTH))
    else $error("result queue fill out of range");

  a_pair_last: assert property (@(posedge clk) disable iff (!rst_n)
    (push_i.cnt == 2'd2) |-> (push_i.r1.last && !push_i.r0.last))
    else $error("last flag misplaced in a result pair");

endmodule

@@ src/expression_line_tokenizer.sv @@
// Top level of the expression line tokenizer: stream ports, scanner and
// result queue. Depends on elt_pkg, elt_scan and elt_rqueue.
//
// Takes one byte per cycle while in_tready is high and turns a line of
// an expression into tokens (kind, start, length). A byte gives zero, one
// or two tokens, written into the result queue as the byte is taken.
// Tokens leave through a four-entry result queue at one per cycle while
// out_tready is high, so the input runs at one byte per cycle while bytes
// average at most one token each; in_tready drops whenever fewer than two
// queue places are free. out_tlast marks the final token of one input byte.
module expression_line_tokenizer
  import elt_pkg::*;
#(
  parameter int unsigned LINE_MAX = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [4:0] token_kind, [12:5] token_start,
                                  // [21:13] token_length, [23:22] zero
  output logic        out_tlast   // last_of_byte
);

  push_t   push;
  result_t res;
  logic    acc;

  assign acc = in_tvalid && in_tready;

  elt_scan #(
    .LINE_MAX (LINE_MAX)
  ) u_scan (
    .clk    (clk),
    .rst_n  (rst_n),
    .acc_i  (acc),
    .char_i (in_tdata),
    .push_o (push)
  );

  elt_rqueue u_rqueue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (push),
    .space_o     (in_tready),
    .out_valid_o (out_tvalid),
    .out_ready_i (out_tready),
    .out_res_o   (res)
  );

  assign out_tdata = {2'b00, res.length, res.start, res.kind};
  assign out_tlast = res.last;

endmodule

@@ tb/sv/expression_line_tokenizer_tb.sv @@
// Self-checking testbench for expression_line_tokenizer: drives byte transfers, predicts the
// token stream in a scoreboard class and checks every output transfer against it.
// Depends on elt_pkg and the expression_line_tokenizer RTL.
module expression_line_tokenizer_tb
  import elt_pkg::*;
();

  localparam int unsigned LINE_MAX = 256;
  localparam int unsigned HOLD_CYCLES = 400;

  class token_scoreboard;
    mode_t       mode;
    bit          pt;
    int unsigned pos;
    int unsigned tbeg;
    int unsigned tcnt;
    logic [7:0]  prefix [PREFIX_BYTES];
    result_t     tokens_due [$];
    int          errors;

    function new();
      errors = 0;
      clear_line();
    endfunction

    function void clear_line();
      mode = MODE_IDLE;
      pt   = 1'b0;
      pos  = 0;
      tbeg = 0;
      tcnt = 0;
      foreach (prefix[i]) prefix[i] = 8'h00;
    endfunction

    function int pending();
      return tokens_due.size();
    endfunction

    function bit is_letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
    endfunction

    function void queue_token(logic [4:0] k, int unsigned s, int unsigned l);
      result_t r;
      r.kind   = k;
      r.start  = s[7:0];
      r.length = l[8:0];
      r.last   = 1'b0;
      tokens_due.push_back(r);
    endfunction

    function bit prefix_is(string s);
      if (tcnt != s.len()) return 1'b0;
      for (int i = 0; i < s.len(); i++)
        if (prefix[i] != s[i]) return 1'b0;
      return 1'b1;
    endfunction

    function logic [4:0] word_class();
      if (prefix_is("sin")) return K_SIN;
      if (prefix_is("cos")) return K_COS;
      if (prefix_is("tan")) return K_TAN;
      if (prefix_is("arcsin")) return K_ARCSIN;
      if (prefix_is("arccos")) return K_ARCCOS;
      if (prefix_is("arctan")) return K_ARCTAN;
      if (prefix_is("log")) return K_LOG;
      return pt ? K_FILE : K_VAR;
    endfunction

    function logic [4:0] operator_code(logic [7:0] c);
      case (c)
        "(":     return K_LPAREN;
        ")":     return K_RPAREN;
        "^":     return K_POWER;
        "+":     return K_PLUS;
        "-":     return K_MINUS;
        "*":     return K_MULT;
        "/":     return K_DIV;
        ",":     return K_COMMA;
        default: return K_UNKNOWN;
      endcase
    endfunction

    function void close_pending();
      if (mode == MODE_NUM) queue_token(K_NUMBER, tbeg, tcnt);
      else if (mode == MODE_WORD) queue_token(word_class(), tbeg, tcnt);
      else if (mode == MODE_COLON) queue_token(K_BAD_COLON, tbeg, 1);
      mode = MODE_IDLE;
      pt   = 1'b0;
    endfunction

    function void start_token(mode_t m, int unsigned p);
      mode = m;
      pt   = 1'b0;
      tbeg = p;
      tcnt = 0;
      foreach (prefix[i]) prefix[i] = 8'h00;
    endfunction

    function void append_char(logic [7:0] c);
      if (tcnt < PREFIX_BYTES) prefix[tcnt] = c;
      tcnt++;
    endfunction

    // one accepted input byte: queue the tokens it causes
    function void note_byte(logic [7:0] c);
      int unsigned n0;
      int unsigned cur;
      bit          taken;
      logic [4:0]  k;
      n0    = tokens_due.size();
      taken = 1'b0;
      if (c == CH_LF || c == CH_CR) begin
        if (mode != MODE_DISCARD) close_pending();
        queue_token(K_NEWLINE, pos, 1);
        clear_line();
      end else if (mode == MODE_DISCARD) begin
      end else if (pos >= LINE_MAX) begin
        close_pending();
        queue_token(K_TOO_LONG, 0, 0);
        mode = MODE_DISCARD;
      end else begin
        cur = pos;
        pos = pos + 1;
        if (mode == MODE_COLON) begin
          if (c == CH_COLON) begin
            queue_token(K_SUCH_THAT, tbeg, 2);
            mode = MODE_IDLE;
          end else begin
            queue_token(K_BAD_COLON, tbeg, 1);
            mode = MODE_DISCARD;
          end
        end else begin
          if (mode == MODE_NUM) begin
            if (is_digit(c) || (c == CH_POINT && !pt)) begin
              if (c == CH_POINT) pt = 1'b1;
              append_char(c);
              taken = 1'b1;
            end else close_pending();
          end else if (mode == MODE_WORD) begin
            if (is_letter(c) || c == CH_USCORE || (c == CH_POINT && !pt)) begin
              if (c == CH_POINT) pt = 1'b1;
              append_char(c);
              taken = 1'b1;
            end else close_pending();
          end
          if (!taken) begin
            if (c == CH_SPACE || c == CH_TAB) begin
            end else if (is_letter(c)) begin
              start_token(MODE_WORD, cur);
              append_char(c);
            end else if (is_digit(c)) begin
              start_token(MODE_NUM, cur);
              append_char(c);
            end else if (c == CH_COLON) begin
              mode = MODE_COLON;
              tbeg = cur;
            end else begin
              k = operator_code(c);
              queue_token(k, cur, 1);
              if (k == K_UNKNOWN) mode = MODE_DISCARD;
            end
          end
        end
      end
      if (tokens_due.size() > n0) tokens_due[tokens_due.size() - 1].last = 1'b1;
    endfunction

    task report(string msg);
      $display("[%0t] token mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic [23:0] d, logic l);
      result_t e;
      if (tokens_due.size() == 0) begin
        report($sformatf("unexpected transfer data %h last %b", d, l));
        return;
      end
      e = tokens_due.pop_front();
      if (d[4:0] != e.kind)
        report($sformatf("kind %0d, expected %0d", d[4:0], e.kind));
      if (d[12:5] != e.start)
        report($sformatf("start %0d, expected %0d", d[12:5], e.start));
      if (d[21:13] != e.length)
        report($sformatf("length %0d, expected %0d", d[21:13], e.length));
      if (d[23:22] != 2'b00)
        report($sformatf("padding bits %b", d[23:22]));
      if (l != e.last)
        report($sformatf("last %b, expected %b", l, e.last));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic        out_tlast;

  token_scoreboard sb;
  logic [7:0]      line_q [$];
  int              sent;
  int              idle_pct;
  int              stall_pct;
  bit              hold_off;
  int              hold_cnt;

  string kw_list [7]   = '{"sin", "cos", "tan", "arcsin", "arccos", "arctan", "log"};
  string near_list [8] = '{"sinh", "co", "Tan", "arcsine", "arc_cos", "logx", "arctan.x",
                           "sin.e"};
  string op_list       = "()^+-*/,";
  int    idle_tab [4]  = '{0, 70, 0, 10};
  int    stall_tab [4] = '{0, 0, 70, 10};

  expression_line_tokenizer #(.LINE_MAX(LINE_MAX)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial begin
    #(12 * 500000);
    $display("expression_line_tokenizer_tb failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);
      if (in_tvalid && in_tready) sb.note_byte(in_tdata);
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_tready <= 1'b0;
        for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++) @(posedge clk);
        hold_off = 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task send_byte(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  task send_queue();
    foreach (line_q[i]) send_byte(line_q[i]);
    line_q.delete();
  endtask

  task drain(input int settle);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  function void put_text(string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endfunction

  function logic [7:0] rand_letter();
    if ($urandom_range(1) == 0) return 8'h41 + 8'($urandom_range(25));
    return 8'h61 + 8'($urandom_range(25));
  endfunction

  function void put_word(bit with_point);
    int n;
    int p;
    n = $urandom_range(7);
    p = with_point ? $urandom_range(n) : -1;
    line_q.push_back(rand_letter());
    for (int i = 0; i < n; i++) begin
      if (i == p) line_q.push_back(CH_POINT);
      line_q.push_back(($urandom_range(4) == 0) ? CH_USCORE : rand_letter());
    end
  endfunction

  function void put_number(bit with_point);
    int n;
    int p;
    n = $urandom_range(1, 6);
    p = with_point ? $urandom_range(n - 1) : -1;
    for (int i = 0; i < n; i++) begin
      line_q.push_back(8'h30 + 8'($urandom_range(9)));
      if (i == p) line_q.push_back(CH_POINT);
    end
  endfunction

  function void put_clean_token();
    case ($urandom_range(9))
      0:       put_text(kw_list[$urandom_range(6)]);
      1:       put_text(near_list[$urandom_range(7)]);
      2, 3:    put_word(1'b0);
      4:       put_number(1'b0);
      5, 6:    line_q.push_back(op_list[$urandom_range(7)]);
      7:       put_text("::");
      8:       put_number(1'b1);
      default: put_word(1'b1);
    endcase
  endfunction

  function void put_sep();
    case ($urandom_range(3))
      0:       begin end
      1:       line_q.push_back(CH_SPACE);
      2:       line_q.push_back(CH_TAB);
      default: put_text("  ");
    endcase
  endfunction

  function void put_noise();
    case ($urandom_range(3))
      0:       line_q.push_back(8'($urandom_range(255)));
      1:       begin
        line_q.push_back(CH_COLON);
        line_q.push_back(8'($urandom_range(255)));
      end
      2:       put_text("1.2.3");
      default: line_q.push_back(8'h80 + 8'($urandom_range(127)));
    endcase
  endfunction

  function void put_line_end();
    case ($urandom_range(3))
      0:       line_q.push_back(CH_CR);
      1:       put_text("\r\n");
      default: line_q.push_back(CH_LF);
    endcase
  endfunction

  task send_line(input bit noisy);
    int ntok;
    ntok = $urandom_range(1, 10);
    for (int i = 0; i < ntok; i++) begin
      if (noisy && $urandom_range(4) == 0) put_noise();
      else put_clean_token();
      put_sep();
    end
    put_line_end();
    send_queue();
  endtask

  // lines reaching or running past LINE_MAX with different tokens pending
  task send_long(input int variant);
    case (variant)
      0: begin
        repeat (LINE_MAX) line_q.push_back("a");
        put_text("b\n");
      end
      1: begin
        repeat (LINE_MAX - 1) line_q.push_back(CH_SPACE);
        put_text(":x\n");
      end
      2: begin
        repeat (LINE_MAX) line_q.push_back("7");
        put_text("+\n");
      end
      3: begin
        repeat (LINE_MAX) line_q.push_back(CH_SPACE);
        line_q.push_back(CH_LF);
      end
      default: begin
        while (line_q.size() < LINE_MAX + 40) begin
          put_clean_token();
          put_sep();
        end
        line_q.push_back(CH_LF);
      end
    endcase
    send_queue();
  endtask

  initial begin
    int nlines;
    int base_sent;
    sb        = new();
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= 8'h00;
    sent      = 0;
    idle_pct  = 0;
    stall_pct = 0;
    hold_off  = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // keyword, number with point, such-that, file name, unknown byte, lone colons
    put_text("arctan(9.5)\n::z.q\r");
    line_q.push_back(8'h00);
    put_text("x\n:+\n:\n");
    send_queue();
    drain(8);

    for (int v = 0; v < 4; v++) send_long(v);
    drain(8);

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = idle_tab[ph];
      stall_pct = stall_tab[ph];
      nlines    = 0;
      if (ph == 0) hold_off = 1'b1;
      if (ph == 3) send_long(4);
      base_sent = sent;
      while (sent < base_sent + 130) begin
        if ($urandom_range(19) == 0) begin
          repeat ($urandom_range(1, 12)) line_q.push_back(8'($urandom_range(255)));
          put_line_end();
          send_queue();
        end else begin
          send_line($urandom_range(4) == 0);
        end
        nlines++;
        if (nlines % 15 == 0) drain(8);
      end
      drain(8);
    end

    drain(20);
    if (sb.errors == 0) begin
      $display("expression_line_tokenizer_tb passed");
    end else begin
      $display("expression_line_tokenizer_tb failed");
    end
    $finish;
  end

endmodule
